// ===== src/hlbc_pkg.sv =====
// Shared types and constants of the hashed LRU block buffer cache tag store.
package hlbc_pkg;

	localparam int BLK_W       = 32;
	localparam int DEV_W       = 8;
	localparam int CNT_W       = 8;
	localparam int DIGIT_W     = 8;
	localparam int DIGITS      = BLK_W / DIGIT_W;
	// device, block, valid and count bits of one entry; the rank follows
	localparam int ENT_FIXED_W = DEV_W + BLK_W + 1 + CNT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		CMD_READ    = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_READ_DISK = 2'd1,
		ST_NO_FREE   = 2'd2,
		ST_UNDERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_EVAL
	} state_t;

	typedef struct packed {
		cmd_t               command;
		logic [DEV_W-1:0]   device;
		logic [BLK_W-1:0]   block_number;
		logic [2:0]         way;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [2:0] set_index;
		logic [2:0] way_used;
	} rsp_t;

endpackage

// ===== src/hlbc_set_mod.sv =====
// Set index unit: block number modulo the set count, one byte per cycle.
module hlbc_set_mod #(
	parameter int SETS = 7,
	parameter int SW   = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [hlbc_pkg::BLK_W-1:0] block_number,
	output logic [SW-1:0]            rem,
	output logic                     done
);
	import hlbc_pkg::*;

	localparam int XW  = SW + DIGIT_W;
	localparam int DCW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [BLK_W-1:0] blk_q;
	logic [SW-1:0]    rem_q;
	logic [DCW-1:0]   cnt_q;
	logic             busy_q;
	logic             done_q;

	// Fold one byte into a remainder below SETS by shifted compare-subtract.
	function automatic logic [XW-1:0] reduce(input logic [XW-1:0] x);
		logic [XW-1:0] v;
		v = x;
		for (int k = DIGIT_W - 1; k >= 0; k--) begin
			if (v >= (XW'(SETS) << k))
				v = v - (XW'(SETS) << k);
		end
		return v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCW'(DIGITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			blk_q <= block_number;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= SW'(reduce({rem_q, blk_q[BLK_W-1 -: DIGIT_W]}));
			blk_q <= blk_q << DIGIT_W;
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

// ===== src/hlbc_tag_ram.sv =====
// Set row memory: one row of all ways per set, registered read, per-row written flags.
module hlbc_tag_ram #(
	parameter int SETS  = 7,
	parameter int SW    = 3,
	parameter int ROW_W = 416
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SW-1:0]    rd_addr,
	input  logic             wr_en,
	input  logic [SW-1:0]    wr_addr,
	input  logic [ROW_W-1:0] wr_row,
	output logic [ROW_W-1:0] rd_row,
	output logic             rd_fresh
);
	logic [ROW_W-1:0] mem [SETS];
	logic [SETS-1:0]  written_q;
	logic [ROW_W-1:0] rd_row_q;
	logic             rd_fresh_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_row;
		if (rd_en)
			rd_row_q <= mem[rd_addr];
	end

	// A row never written reads as the reset row; the update logic supplies it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			rd_fresh_q <= 1'b1;
		end else begin
			if (wr_en)
				written_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_fresh_q <= !written_q[rd_addr];
		end
	end

	assign rd_row   = rd_row_q;
	assign rd_fresh = rd_fresh_q;

endmodule

// ===== src/hlbc_row_update.sv =====
// Row update: lookup, victim choice, count and recency changes on one set row.
module hlbc_row_update #(
	parameter int WAYS = 8,
	parameter int IW   = 3
) (
	input  logic [WAYS*(hlbc_pkg::ENT_FIXED_W+IW)-1:0] row,
	input  logic                                       fresh,
	input  hlbc_pkg::req_t                             req,
	output logic [WAYS*(hlbc_pkg::ENT_FIXED_W+IW)-1:0] row_new,
	output hlbc_pkg::status_t                          status,
	output logic [2:0]                                 way_used
);
	import hlbc_pkg::*;

	typedef struct packed {
		logic [DEV_W-1:0] device;
		logic [BLK_W-1:0] block_number;
		logic             valid;
		logic [CNT_W-1:0] count;
		logic [IW-1:0]    rank;
	} entry_t;

	entry_t [WAYS-1:0] ent_raw;
	entry_t [WAYS-1:0] ent;
	entry_t [WAYS-1:0] ent_new;
	logic   [WAYS-1:0] match;
	logic   [WAYS-1:0] free;
	logic   [WAYS-1:0] hit_sel;
	logic   [WAYS-1:0] vic_sel;
	logic   [IW-1:0]   pick;
	logic   [IW-1:0]   widx;
	logic              hit;
	logic              any_free;
	logic              way_ok;

	function automatic logic [IW-1:0] encode(input logic [WAYS-1:0] sel);
		logic [IW-1:0] idx;
		idx = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (sel[w])
				idx = idx | IW'(w);
		end
		return idx;
	endfunction

	assign ent_raw = row;
	assign widx    = IW'(req.way);
	assign way_ok  = 32'(req.way) < WAYS;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (fresh) begin
				ent[w]      = '0;
				ent[w].rank = IW'(WAYS - 1 - w);
			end else begin
				ent[w] = ent_raw[w];
			end
		end
	end

	// Most recent matching way wins a hit; least recent free way is the victim.
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match[w] = (ent[w].device == req.device) &&
				(ent[w].block_number == req.block_number);
			free[w]  = (ent[w].count == '0);
		end
		for (int w = 0; w < WAYS; w++) begin
			hit_sel[w] = match[w];
			vic_sel[w] = free[w];
			for (int k = 0; k < WAYS; k++) begin
				if (match[k] && (ent[k].rank < ent[w].rank))
					hit_sel[w] = 1'b0;
				if (free[k] && (ent[k].rank > ent[w].rank))
					vic_sel[w] = 1'b0;
			end
		end
	end

	assign hit      = |match;
	assign any_free = |free;
	assign pick     = hit ? encode(hit_sel) : encode(vic_sel);

	always_comb begin
		ent_new  = ent;
		status   = ST_OK;
		way_used = req.way;
		case (req.command)
			CMD_READ: begin
				if (hit || any_free) begin
					if (!hit) begin
						ent_new[pick].device       = req.device;
						ent_new[pick].block_number = req.block_number;
						ent_new[pick].valid        = 1'b0;
						ent_new[pick].count        = CNT_W'(1);
					end else if (ent[pick].count != CNT_MAX) begin
						ent_new[pick].count = ent[pick].count + 1'b1;
					end
					if (!ent_new[pick].valid)
						status = ST_READ_DISK;
					ent_new[pick].valid = 1'b1;
					way_used = 3'(pick);
				end else begin
					status   = ST_NO_FREE;
					way_used = '0;
				end
			end
			default: begin
				if (way_ok) begin
					if (req.command == CMD_PIN) begin
						if (ent[widx].count != CNT_MAX)
							ent_new[widx].count = ent[widx].count + 1'b1;
					end else if (ent[widx].count == '0) begin
						status = ST_UNDERFLOW;
					end else begin
						ent_new[widx].count = ent[widx].count - 1'b1;
						// last release: promote to most recent
						if (req.command == CMD_RELEASE && ent[widx].count == CNT_W'(1)) begin
							for (int k = 0; k < WAYS; k++) begin
								if (ent[k].rank < ent[widx].rank)
									ent_new[k].rank = ent[k].rank + 1'b1;
							end
							ent_new[widx].rank = '0;
						end
					end
				end
			end
		endcase
	end

	assign row_new = ent_new;

endmodule

// ===== src/hashed_lru_block_buffer_cache_core.sv =====
// Top level of the hashed LRU block buffer cache tag store.
//
//  channel | dir | handshake       | word
//  --------+-----+-----------------+------------------------------------------
//  req     | in  | req_valid/stall | command, device, block_number, way
//  rsp     | out | rsp_valid/stall | status, set_index, way_used
//
// A request passes the set index unit (block number mod SETS, one byte per
// cycle), the registered read of its set row, and the update and write-back
// of that row, which waits until the output register is free.
// Reset clears the control state and the per-row written flags; rows never
// written read as the reset row, so no clearing pass is needed.
// req_stall is high while a request is in flight. A stalled response holds in
// the output register while the next request is already being worked on.
module hashed_lru_block_buffer_cache_core #(
	parameter int SETS = 7,
	parameter int WAYS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  hlbc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output hlbc_pkg::rsp_t rsp
);
	import hlbc_pkg::*;

	localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W = WAYS * (ENT_FIXED_W + IW);

	state_t           state_q;
	state_t           state_d;
	req_t             req_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             accept;
	logic             mod_start;
	logic             mod_done;
	logic [SW-1:0]    set_idx;
	logic             rd_en;
	logic             wr_en;
	logic             rsp_free;
	logic [ROW_W-1:0] rd_row;
	logic             rd_fresh;
	logic [ROW_W-1:0] row_new;
	status_t          upd_status;
	logic [2:0]       upd_way;

	// Set index: remainder of the block number, held until the next start.
	hlbc_set_mod #(
		.SETS (SETS),
		.SW   (SW)
	) u_set_mod (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mod_start),
		.block_number (req.block_number),
		.rem          (set_idx),
		.done         (mod_done)
	);

	// Row memory. Read and write of one request sit in different cycles and
	// requests do not overlap, so the write always lands before the next read.
	hlbc_tag_ram #(
		.SETS  (SETS),
		.SW    (SW),
		.ROW_W (ROW_W)
	) u_tag_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (set_idx),
		.wr_en    (wr_en),
		.wr_addr  (set_idx),
		.wr_row   (row_new),
		.rd_row   (rd_row),
		.rd_fresh (rd_fresh)
	);

	hlbc_row_update #(
		.WAYS (WAYS),
		.IW   (IW)
	) u_row_update (
		.row      (rd_row),
		.fresh    (rd_fresh),
		.req      (req_q),
		.row_new  (row_new),
		.status   (upd_status),
		.way_used (upd_way)
	);

	// Output register frees up when empty or when its word is taken this cycle.
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid)
					state_d = S_MOD;
			end
			S_MOD: begin
				if (mod_done)
					state_d = S_EVAL;
			end
			S_EVAL: begin
				if (rsp_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != S_IDLE);
		accept    = (state_q == S_IDLE) && req_valid;
		mod_start = accept;
		rd_en     = (state_q == S_MOD) && mod_done;
		wr_en     = (state_q == S_EVAL) && rsp_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// Hold the request for the update; load the response word on writeback.
	always_ff @(posedge clk) begin
		if (accept)
			req_q <= req;
		if (wr_en) begin
			rsp_q.status    <= upd_status;
			rsp_q.set_index <= 3'(set_idx);
			rsp_q.way_used  <= upd_way;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_accept_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request channel still open after accepting a word");

	a_mod_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && mod_done) |=> (state_q == S_EVAL))
		else $error("row read issued without moving to update");

	a_nofree_way: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_NO_FREE) |-> (rsp.way_used == 3'd0))
		else $error("no-free response carries a nonzero way");

	a_set_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((32'(rsp.set_index) < SETS) || (SETS > 8)))
		else $error("response set index out of range");
`endif

endmodule
